### hw/rtl/lift_carriage_sequencer_top_defines.svh
// Assertion macros shared by the lift carriage sequencer RTL.
// Each macro expands to one labeled concurrent assertion, disabled while the active-low reset is asserted.
`ifndef LIFT_CARRIAGE_SEQUENCER_TOP_DEFINES_SVH
`define LIFT_CARRIAGE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define LCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lcs_pkg.sv
// Package for the lift carriage sequencer: beat types, phase and drive codes, timing constants.
// No dependencies.
`timescale 1ns / 1ps

package lcs_pkg;

    // Input beat: one control pass
    typedef struct packed {
        logic [31:0] now_ms;
        logic        at_lower;
        logic        at_upper;
        logic        near_limit;
        logic [14:0] echo_us;
        logic [7:0]  host_mode;
        logic        chirp_phase;
        logic        descend_ok;
        logic        ramp_shut;
    } t_in_beat;

    // Output beat: phase, bridge command, lamp and homed flag
    typedef struct packed {
        logic [2:0] lift_phase;
        logic [1:0] drive_dir;
        logic [7:0] drive_duty;
        logic       led_on;
        logic       homed;
    } t_out_beat;

    // Sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_HOME   = 5'b00001,
        PH_IDLE   = 5'b00010,
        PH_UP     = 5'b00100,
        PH_STAGED = 5'b01000,
        PH_DOWN   = 5'b10000
    } t_phase;

    // Phase codes as reported on the output
    localparam logic [2:0] PCODE_HOME   = 3'd0;
    localparam logic [2:0] PCODE_IDLE   = 3'd1;
    localparam logic [2:0] PCODE_UP     = 3'd2;
    localparam logic [2:0] PCODE_STAGED = 3'd3;
    localparam logic [2:0] PCODE_DOWN   = 3'd4;

    // Bridge direction codes
    localparam logic [1:0] DIR_OFF  = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Host modes
    localparam logic [7:0] MODE_MANUAL = 8'd0;
    localparam logic [7:0] MODE_HOMING = 8'd1;
    localparam logic [7:0] MODE_PAUSED = 8'd98;
    localparam logic [7:0] MODE_STOP   = 8'd99;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_DUTY   = 2'd0;
    localparam logic [1:0] CFG_RAMP_STEP  = 2'd1;
    localparam logic [1:0] CFG_BRICK_NEAR = 2'd2;
    localparam logic [1:0] CFG_BRICK_FAR  = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_MAX_DUTY   = 8'd200;
    localparam logic [7:0]  RST_RAMP_STEP  = 8'd10;
    localparam logic [14:0] RST_BRICK_NEAR = 15'd30;
    localparam logic [14:0] RST_BRICK_FAR  = 15'd352;

    // Sequencer timing in ms
    localparam logic [31:0] CONFIRM_MS = 32'd2000;
    localparam logic [31:0] GRACE_MS   = 32'd500;
    localparam logic [31:0] TIMEOUT_MS = 32'd4000;
    localparam logic [31:0] PAUSE_MS   = 32'd1000;

    // One-hot phase to reported code
    function automatic logic [2:0] f_phase_code(input t_phase ph);
        logic [2:0] code;
        code = PCODE_IDLE;
        case (ph)
            PH_HOME:   code = PCODE_HOME;
            PH_IDLE:   code = PCODE_IDLE;
            PH_UP:     code = PCODE_UP;
            PH_STAGED: code = PCODE_STAGED;
            PH_DOWN:   code = PCODE_DOWN;
            default:   code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/lift_carriage_sequencer_top.sv
// Lift carriage sequencer: five-phase lift state machine driving an H-bridge.
// Depends on lcs_pkg and lift_carriage_sequencer_top_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one control pass
//   per beat: timestamp, limit switches, echo width, host mode and host flags.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one beat per
//   input beat: phase, limit-clamped bridge direction and duty, lamp, homed flag.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes max duty, ramp step
//   and the brick echo window; write only while no beat is in flight.
// Path: an input beat is captured in the input register, then goes through the
//   sequencer logic into the output register.
// Throughput: one beat per cycle while the output is not stalled; the sequencer
//   state updates together with the output register, so passes follow back to back.
// Reset: synchronous, active low; phase returns to idle, all timers, flags and
//   duty clear, config registers return to their defaults, both stages empty.
// Stall: a stalled output beat holds; an empty input register still takes one
//   more beat, then o_in_stall rises until the output side drains.
`timescale 1ns / 1ps
`include "lift_carriage_sequencer_top_defines.svh"

module lift_carriage_sequencer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lcs_pkg::t_in_beat i_in_data,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lcs_pkg::t_out_beat o_out_data,
    // config write port
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [14:0]       i_cfg_data
);

    // config registers
    logic [7:0]  r_max_duty;
    logic [7:0]  r_ramp_step;
    logic [14:0] r_brick_near;
    logic [14:0] r_brick_far;

    // pipeline registers
    logic               r_in_valid;
    lcs_pkg::t_in_beat  r_in;
    logic               r_out_valid;
    lcs_pkg::t_out_beat r_out;
    lcs_pkg::t_out_beat n_out;

    // sequencer state
    lcs_pkg::t_phase r_phase, n_phase;
    logic        r_confirm_pending, n_confirm_pending;
    logic [31:0] r_detect_time, n_detect_time;
    logic [31:0] r_lost_time, n_lost_time;
    logic        r_lost_armed, n_lost_armed;
    logic        r_ramp_seen_open, n_ramp_seen_open;
    logic [31:0] r_last_step_time, n_last_step_time;
    logic [7:0]  r_duty_level, n_duty_level;
    logic        r_pause_armed, n_pause_armed;
    logic [31:0] r_pause_start, n_pause_start;
    logic        r_homed_flag, n_homed_flag;
    logic [7:0]  r_prev_mode, n_prev_mode;
    logic        r_lamp, n_lamp;

    logic out_ready;
    logic pass_fire;

    // handshake: output register frees when empty or taken this cycle
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign pass_fire   = r_in_valid && out_ready;
    assign o_in_stall  = r_in_valid && !out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty   <= lcs_pkg::RST_MAX_DUTY;
            r_ramp_step  <= lcs_pkg::RST_RAMP_STEP;
            r_brick_near <= lcs_pkg::RST_BRICK_NEAR;
            r_brick_far  <= lcs_pkg::RST_BRICK_FAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcs_pkg::CFG_MAX_DUTY:   r_max_duty   <= i_cfg_data[7:0];
                lcs_pkg::CFG_RAMP_STEP:  r_ramp_step  <= i_cfg_data[7:0];
                lcs_pkg::CFG_BRICK_NEAR: r_brick_near <= i_cfg_data;
                lcs_pkg::CFG_BRICK_FAR:  r_brick_far  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // sequencer pass
    always_comb begin
        logic        seen;
        logic [31:0] on_for;
        logic [31:0] step_age;
        logic [1:0]  cmd_dir;
        logic [7:0]  cmd_duty;
        logic [1:0]  fin_dir;
        logic [7:0]  fin_duty;

        n_phase           = r_phase;
        n_confirm_pending = r_confirm_pending;
        n_detect_time     = r_detect_time;
        n_lost_time       = r_lost_time;
        n_lost_armed      = r_lost_armed;
        n_ramp_seen_open  = r_ramp_seen_open;
        n_last_step_time  = r_last_step_time;
        n_duty_level      = r_duty_level;
        n_pause_armed     = r_pause_armed;
        n_pause_start     = r_pause_start;
        n_homed_flag      = r_homed_flag;
        n_prev_mode       = r_in.host_mode;
        n_lamp            = r_lamp;
        cmd_dir           = lcs_pkg::DIR_OFF;
        cmd_duty          = 8'd0;
        on_for            = 32'd0;

        seen = (r_in.echo_us != 15'd0) && (r_in.echo_us >= r_brick_near)
            && (r_in.echo_us <= r_brick_far);
        step_age = r_in.now_ms - r_last_step_time;

        // a fresh homing request drops the homed flag
        if (r_in.host_mode != r_prev_mode && r_in.host_mode == lcs_pkg::MODE_HOMING) begin
            n_homed_flag = 1'b0;
        end

        case (r_phase)
            lcs_pkg::PH_HOME: begin
                cmd_dir  = lcs_pkg::DIR_DOWN;
                cmd_duty = r_max_duty;
                if (r_in.at_lower) begin
                    cmd_dir = lcs_pkg::DIR_OFF;
                    n_phase = lcs_pkg::PH_IDLE;
                end
            end
            lcs_pkg::PH_IDLE: begin
                if (r_in.at_lower && n_homed_flag
                        && r_in.host_mode != lcs_pkg::MODE_MANUAL) begin
                    // first sighting starts the confirm window
                    if (seen && !n_confirm_pending) begin
                        n_detect_time     = r_in.now_ms;
                        n_confirm_pending = 1'b1;
                        n_lamp            = 1'b1;
                        n_lost_armed      = 1'b0;
                    end
                    if (n_confirm_pending) begin
                        on_for = r_in.now_ms - n_detect_time;
                        if (on_for >= lcs_pkg::CONFIRM_MS && seen && r_in.descend_ok) begin
                            n_phase           = lcs_pkg::PH_UP;
                            n_ramp_seen_open  = 1'b0;
                            n_confirm_pending = 1'b0;
                            n_lost_armed      = 1'b0;
                            n_lamp            = 1'b0;
                        end
                        // loss grace
                        if (!seen) begin
                            if (!n_lost_armed) begin
                                n_lost_time  = r_in.now_ms;
                                n_lost_armed = 1'b1;
                            end
                            if ((r_in.now_ms - n_lost_time) >= lcs_pkg::GRACE_MS) begin
                                n_confirm_pending = 1'b0;
                                n_lost_armed      = 1'b0;
                                n_lamp            = 1'b0;
                            end
                        end else begin
                            n_lost_armed = 1'b0;
                        end
                        // overall timeout
                        if (on_for > lcs_pkg::TIMEOUT_MS && !seen) begin
                            n_confirm_pending = 1'b0;
                            n_lamp            = 1'b0;
                        end
                    end
                end
            end
            lcs_pkg::PH_UP: begin
                if (step_age >= {24'd0, r_ramp_step}) begin
                    if (r_duty_level < r_max_duty) n_duty_level = r_duty_level + 8'd1;
                    n_last_step_time = r_in.now_ms;
                end
                cmd_dir  = lcs_pkg::DIR_UP;
                cmd_duty = n_duty_level;
                if (r_in.at_upper) begin
                    cmd_dir      = lcs_pkg::DIR_OFF;
                    n_duty_level = 8'd0;
                    n_phase      = lcs_pkg::PH_STAGED;
                end else begin
                    if (!r_in.ramp_shut) n_ramp_seen_open = 1'b1;
                    if (n_ramp_seen_open && r_in.ramp_shut) begin
                        cmd_dir      = lcs_pkg::DIR_OFF;
                        n_duty_level = 8'd0;
                        n_phase      = lcs_pkg::PH_STAGED;
                    end
                end
            end
            lcs_pkg::PH_STAGED: begin
                n_duty_level = 8'd0;
                if (!r_pause_armed) begin
                    n_pause_start = r_in.now_ms;
                    n_pause_armed = 1'b1;
                end else if ((r_in.now_ms - r_pause_start) >= lcs_pkg::PAUSE_MS
                        && r_in.descend_ok) begin
                    n_pause_armed = 1'b0;
                    n_phase       = lcs_pkg::PH_DOWN;
                end
            end
            lcs_pkg::PH_DOWN: begin
                if (step_age >= {24'd0, r_ramp_step}) begin
                    if (r_duty_level < r_max_duty) n_duty_level = r_duty_level + 8'd1;
                    n_last_step_time = r_in.now_ms;
                end
                if (r_in.at_lower) begin
                    n_duty_level = 8'd0;
                    n_phase      = lcs_pkg::PH_IDLE;
                end else begin
                    cmd_dir  = lcs_pkg::DIR_DOWN;
                    cmd_duty = n_duty_level;
                end
            end
            default: ;
        endcase

        // host mode overrides
        if (r_in.host_mode == lcs_pkg::MODE_MANUAL) begin
            n_phase           = lcs_pkg::PH_IDLE;
            cmd_dir           = lcs_pkg::DIR_OFF;
            n_confirm_pending = 1'b0;
        end else if (r_in.host_mode == lcs_pkg::MODE_HOMING) begin
            if (!r_in.chirp_phase) begin
                n_phase = lcs_pkg::PH_HOME;
                if (r_in.near_limit) n_homed_flag = 1'b1;
            end
        end else if (r_in.host_mode inside {lcs_pkg::MODE_PAUSED, lcs_pkg::MODE_STOP}) begin
            cmd_dir = lcs_pkg::DIR_OFF;
        end

        // zero duty means off, off means zero duty
        fin_dir  = (cmd_duty == 8'd0) ? lcs_pkg::DIR_OFF : cmd_dir;
        fin_duty = (fin_dir == lcs_pkg::DIR_OFF) ? 8'd0 : cmd_duty;

        // limit clamp
        if ((fin_dir == lcs_pkg::DIR_UP && r_in.at_upper)
                || (fin_dir == lcs_pkg::DIR_DOWN && r_in.at_lower)) begin
            fin_dir  = lcs_pkg::DIR_OFF;
            fin_duty = 8'd0;
        end

        n_out.lift_phase = lcs_pkg::f_phase_code(n_phase);
        n_out.drive_dir  = fin_dir;
        n_out.drive_duty = fin_duty;
        n_out.led_on     = n_lamp;
        n_out.homed      = n_homed_flag;
    end

    // sequencer state, updated once per pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= lcs_pkg::PH_IDLE;
            r_confirm_pending <= 1'b0;
            r_detect_time     <= 32'd0;
            r_lost_time       <= 32'd0;
            r_lost_armed      <= 1'b0;
            r_ramp_seen_open  <= 1'b0;
            r_last_step_time  <= 32'd0;
            r_duty_level      <= 8'd0;
            r_pause_armed     <= 1'b0;
            r_pause_start     <= 32'd0;
            r_homed_flag      <= 1'b0;
            r_prev_mode       <= 8'd0;
            r_lamp            <= 1'b0;
        end else if (pass_fire) begin
            r_phase           <= n_phase;
            r_confirm_pending <= n_confirm_pending;
            r_detect_time     <= n_detect_time;
            r_lost_time       <= n_lost_time;
            r_lost_armed      <= n_lost_armed;
            r_ramp_seen_open  <= n_ramp_seen_open;
            r_last_step_time  <= n_last_step_time;
            r_duty_level      <= n_duty_level;
            r_pause_armed     <= n_pause_armed;
            r_pause_start     <= n_pause_start;
            r_homed_flag      <= n_homed_flag;
            r_prev_mode       <= n_prev_mode;
            r_lamp            <= n_lamp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass_fire) begin
            r_out <= n_out;
        end
    end

    // checks
    `LCS_ASSERT_IMPLY(a_drive_has_duty, i_clk, i_rst_n, r_out_valid && r_out.drive_dir != lcs_pkg::DIR_OFF, r_out.drive_duty != 8'd0, "active drive beat with zero duty")
    `LCS_ASSERT_IMPLY(a_confirm_lamp, i_clk, i_rst_n, r_confirm_pending, r_lamp, "confirm pending with lamp off")
    `LCS_ASSERT_NEXT(a_held_pass_kept, i_clk, i_rst_n, r_in_valid && !out_ready, r_in_valid && $stable(r_in), "held pass lost from input register")

endmodule
